@@ hdl/wdrl_pkg.sv @@
`default_nettype none

package wdrl_pkg;

  localparam int DEF_WAIT_DEPTH = 8;
  localparam int DEF_ID_BITS    = 16;
  localparam int DEF_PRIO_BITS  = 32;

  localparam int DATA_BITS    = 32;
  localparam int PADDR_BITS   = 3;
  localparam int REG_IDX_BITS = 1;
  localparam int MAXW_BITS    = 4;

  localparam logic [REG_IDX_BITS-1:0] REG_LOCK_POLICY = 1'b0;
  localparam logic [REG_IDX_BITS-1:0] REG_MAX_WAITERS = 1'b1;

  localparam logic                 POLICY_RESET   = 1'b1;
  localparam logic [MAXW_BITS-1:0] MAX_WAIT_RESET = 4'd8;

  localparam logic POLICY_NO_WAIT  = 1'b0;
  localparam logic POLICY_WAIT_DIE = 1'b1;

  localparam logic MODE_LOCK    = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_GRANT    = 2'd0,
    ST_WAIT     = 2'd1,
    ST_ABORT    = 2'd2,
    ST_RELEASED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_t;

  typedef struct packed {
    logic wr;
    logic drop;
  } cell_ctl_t;

  typedef struct packed {
    logic match;
    logic free;
    logic best;
  } scan_flags_t;

endpackage

`default_nettype wire

@@ hdl/wdrl_req_if.sv @@
`default_nettype none

interface wdrl_req_if #(
  parameter int ID_BITS   = wdrl_pkg::DEF_ID_BITS,
  parameter int PRIO_BITS = wdrl_pkg::DEF_PRIO_BITS
);
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [ID_BITS-1:0]   txn_id;
  logic [PRIO_BITS-1:0] txn_priority;

  modport source (output valid, mode, txn_id, txn_priority, input ready);
  modport sink   (input valid, mode, txn_id, txn_priority, output ready);
endinterface

`default_nettype wire

@@ hdl/wdrl_rsp_if.sv @@
`default_nettype none

interface wdrl_rsp_if #(
  parameter int ID_BITS = wdrl_pkg::DEF_ID_BITS
);
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               wake_valid;
  logic [ID_BITS-1:0] wake_txn_id;

  modport source (output valid, status, wake_valid, wake_txn_id, input ready);
  modport sink   (input valid, status, wake_valid, wake_txn_id, output ready);
endinterface

`default_nettype wire

@@ hdl/wdrl_cell.sv @@
`default_nettype none

module wdrl_cell #(
  parameter int WAIT_DEPTH = wdrl_pkg::DEF_WAIT_DEPTH,
  parameter int ID_BITS    = wdrl_pkg::DEF_ID_BITS,
  parameter int PRIO_BITS  = wdrl_pkg::DEF_PRIO_BITS,
  parameter int IDX        = 0,
  localparam int IW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1,
  localparam int NW = $clog2(WAIT_DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  wdrl_pkg::cell_ctl_t    ctl,
  input  logic [ID_BITS-1:0]     wr_id,
  input  logic [PRIO_BITS-1:0]   wr_prio,
  input  logic [PRIO_BITS-1:0]   key,
  input  wdrl_pkg::scan_flags_t  flg_in,
  input  logic [IW-1:0]          match_idx_in,
  input  logic [IW-1:0]          free_idx_in,
  input  logic [IW-1:0]          best_idx_in,
  input  logic [PRIO_BITS-1:0]   best_prio_in,
  input  logic [ID_BITS-1:0]     best_id_in,
  input  logic [NW-1:0]          count_in,
  output wdrl_pkg::scan_flags_t  flg_out,
  output logic [IW-1:0]          match_idx_out,
  output logic [IW-1:0]          free_idx_out,
  output logic [IW-1:0]          best_idx_out,
  output logic [PRIO_BITS-1:0]   best_prio_out,
  output logic [ID_BITS-1:0]     best_id_out,
  output logic [NW-1:0]          count_out,
  output logic                   occupied
);
  import wdrl_pkg::*;

  logic                 valid;
  logic [ID_BITS-1:0]   id;
  logic [PRIO_BITS-1:0] prio;
  logic                 take_best;

  assign occupied  = valid;
  assign take_best = valid && (!flg_in.best || prio > best_prio_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.wr) begin
      valid <= 1'b1;
    end else if (ctl.drop) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      id   <= wr_id;
      prio <= wr_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flg_out <= '0;
    end else begin
      flg_out.match <= flg_in.match || (valid && prio == key);
      flg_out.free  <= flg_in.free || !valid;
      flg_out.best  <= flg_in.best || valid;
    end
  end

  always_ff @(posedge clk) begin
    match_idx_out <= (flg_in.match || !(valid && prio == key)) ? match_idx_in : IW'(IDX);
    free_idx_out  <= (flg_in.free || valid) ? free_idx_in : IW'(IDX);
    best_idx_out  <= take_best ? IW'(IDX) : best_idx_in;
    best_prio_out <= take_best ? prio : best_prio_in;
    best_id_out   <= take_best ? id : best_id_in;
    count_out     <= count_in + NW'(valid);
  end

endmodule

`default_nettype wire

@@ hdl/wdrl_cfg.sv @@
`default_nettype none

module wdrl_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [wdrl_pkg::PADDR_BITS-1:0]      paddr,
  input  logic [wdrl_pkg::DATA_BITS-1:0]       pwdata,
  output logic [wdrl_pkg::DATA_BITS-1:0]       prdata,
  output logic                                 pready,
  output logic                                 lock_policy,
  output logic [wdrl_pkg::MAXW_BITS-1:0]       max_waiters
);
  import wdrl_pkg::*;

  logic [REG_IDX_BITS-1:0] reg_idx;
  logic                    wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_BITS-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_policy <= POLICY_RESET;
      max_waiters <= MAX_WAIT_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LOCK_POLICY: lock_policy <= pwdata[0];
        REG_MAX_WAITERS: max_waiters <= pwdata[MAXW_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LOCK_POLICY: prdata = {{(DATA_BITS-1){1'b0}}, lock_policy};
      REG_MAX_WAITERS: prdata = {{(DATA_BITS-MAXW_BITS){1'b0}}, max_waiters};
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/wait_die_row_lock.sv @@
`default_nettype none

// Exclusive lock arbiter for one row. Each request or release transaction is
// accepted on req and answered by exactly one result on rsp. Waiters live in a
// row of WAIT_DEPTH cells; a search record walks through the row one cell per
// clock, collecting the matching waiter, the first free slot, the waiter with
// the largest priority and the waiter count. An item passes from acceptance
// through the capture registers, the walk through the cells in S_SCAN and
// S_DECIDE, which holds while the last result is not yet taken, to its result
// register; the next item is accepted in the cycle after the decision, even
// while that result still waits on rsp. Registers: lock_policy at 0x0 (reset
// 1, wait-die) and max_waiters at 0x4 (reset 8); write them only while idle.

module wait_die_row_lock #(
  parameter int WAIT_DEPTH = wdrl_pkg::DEF_WAIT_DEPTH,
  parameter int ID_BITS    = wdrl_pkg::DEF_ID_BITS,
  parameter int PRIO_BITS  = wdrl_pkg::DEF_PRIO_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  wdrl_req_if.sink                        req,
  wdrl_rsp_if.source                      rsp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wdrl_pkg::PADDR_BITS-1:0] paddr,
  input  logic [wdrl_pkg::DATA_BITS-1:0]  pwdata,
  output logic [wdrl_pkg::DATA_BITS-1:0]  prdata,
  output logic                            pready
);
  import wdrl_pkg::*;

  localparam int IW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int NW = $clog2(WAIT_DEPTH + 1);

  state_t state, state_next;
  logic [IW-1:0] cnt;
  logic          req_ready;
  logic          fire;

  logic                 mode_q;
  logic [ID_BITS-1:0]   id_q;
  logic [PRIO_BITS-1:0] prio_q;

  logic                 owner_valid;
  logic [ID_BITS-1:0]   owner_id;
  logic [PRIO_BITS-1:0] owner_prio;

  logic                 lock_policy;
  logic [MAXW_BITS-1:0] max_waiters;

  scan_flags_t          flg       [WAIT_DEPTH+1];
  logic [IW-1:0]        match_idx [WAIT_DEPTH+1];
  logic [IW-1:0]        free_idx  [WAIT_DEPTH+1];
  logic [IW-1:0]        best_idx  [WAIT_DEPTH+1];
  logic [PRIO_BITS-1:0] best_prio [WAIT_DEPTH+1];
  logic [ID_BITS-1:0]   best_id   [WAIT_DEPTH+1];
  logic [NW-1:0]        count     [WAIT_DEPTH+1];

  cell_ctl_t             ctl [WAIT_DEPTH];
  logic [WAIT_DEPTH-1:0] occ;
  logic [WAIT_DEPTH-1:0] wr_vec;
  logic [WAIT_DEPTH-1:0] drop_vec;

  status_t              status_d;
  logic                 wake_d;
  logic [ID_BITS-1:0]   wake_id_d;
  logic                 do_wr;
  logic                 do_drop;
  logic [IW-1:0]        drop_idx;
  logic                 own_wr;
  logic                 own_valid_d;
  logic [ID_BITS-1:0]   own_id_d;
  logic [PRIO_BITS-1:0] own_prio_d;
  logic                 full;

  logic               rsp_valid;
  status_t            rsp_status;
  logic               rsp_wake;
  logic [ID_BITS-1:0] rsp_wake_id;

  wdrl_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .lock_policy (lock_policy),
    .max_waiters (max_waiters)
  );

  assign flg[0]       = '0;
  assign match_idx[0] = '0;
  assign free_idx[0]  = '0;
  assign best_idx[0]  = '0;
  assign best_prio[0] = '0;
  assign best_id[0]   = '0;
  assign count[0]     = '0;

  for (genvar i = 0; i < WAIT_DEPTH; i++) begin : g_cell
    assign wr_vec[i]   = fire && do_wr && free_idx[WAIT_DEPTH] == IW'(i);
    assign drop_vec[i] = fire && do_drop && drop_idx == IW'(i);
    assign ctl[i]      = '{wr: wr_vec[i], drop: drop_vec[i]};

    wdrl_cell #(
      .WAIT_DEPTH (WAIT_DEPTH),
      .ID_BITS    (ID_BITS),
      .PRIO_BITS  (PRIO_BITS),
      .IDX        (i)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctl           (ctl[i]),
      .wr_id         (id_q),
      .wr_prio       (prio_q),
      .key           (prio_q),
      .flg_in        (flg[i]),
      .match_idx_in  (match_idx[i]),
      .free_idx_in   (free_idx[i]),
      .best_idx_in   (best_idx[i]),
      .best_prio_in  (best_prio[i]),
      .best_id_in    (best_id[i]),
      .count_in      (count[i]),
      .flg_out       (flg[i+1]),
      .match_idx_out (match_idx[i+1]),
      .free_idx_out  (free_idx[i+1]),
      .best_idx_out  (best_idx[i+1]),
      .best_prio_out (best_prio[i+1]),
      .best_id_out   (best_id[i+1]),
      .count_out     (count[i+1]),
      .occupied      (occ[i])
    );
  end

  assign req.ready       = req_ready;
  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.wake_valid  = rsp_wake;
  assign rsp.wake_txn_id = rsp_wake_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    fire       = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req.valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt == IW'(WAIT_DEPTH - 1)) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!rsp_valid || rsp.ready) begin
          fire       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == S_SCAN) begin
      cnt <= cnt + IW'(1);
    end else begin
      cnt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req_ready) begin
      mode_q <= req.mode;
      id_q   <= req.txn_id;
      prio_q <= req.txn_priority;
    end
  end

  always_comb begin
    status_d    = ST_RELEASED;
    wake_d      = 1'b0;
    wake_id_d   = '0;
    do_wr       = 1'b0;
    do_drop     = 1'b0;
    drop_idx    = match_idx[WAIT_DEPTH];
    own_wr      = 1'b0;
    own_valid_d = owner_valid;
    own_id_d    = owner_id;
    own_prio_d  = owner_prio;
    full        = (32'(count[WAIT_DEPTH]) >= 32'(max_waiters))
               || (32'(count[WAIT_DEPTH]) >= 32'(WAIT_DEPTH));
    if (mode_q == MODE_LOCK) begin
      priority if (!owner_valid || owner_id == id_q) begin
        status_d    = ST_GRANT;
        own_wr      = 1'b1;
        own_valid_d = 1'b1;
        own_id_d    = id_q;
        own_prio_d  = prio_q;
      end else if (lock_policy == POLICY_NO_WAIT) begin
        status_d = ST_ABORT;
      end else if (full || !(prio_q < owner_prio)) begin
        status_d = ST_ABORT;
      end else begin
        status_d = ST_WAIT;
        do_wr    = !flg[WAIT_DEPTH].match;
      end
    end else begin
      priority if (!owner_valid || owner_id != id_q) begin
        do_drop = flg[WAIT_DEPTH].match;
      end else if (flg[WAIT_DEPTH].best) begin
        own_wr     = 1'b1;
        own_id_d   = best_id[WAIT_DEPTH];
        own_prio_d = best_prio[WAIT_DEPTH];
        do_drop    = 1'b1;
        drop_idx   = best_idx[WAIT_DEPTH];
        wake_d     = 1'b1;
        wake_id_d  = best_id[WAIT_DEPTH];
      end else begin
        own_wr      = 1'b1;
        own_valid_d = 1'b0;
        own_id_d    = '0;
        own_prio_d  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owner_valid <= 1'b0;
      owner_id    <= '0;
      owner_prio  <= '0;
    end else if (fire && own_wr) begin
      owner_valid <= own_valid_d;
      owner_id    <= own_id_d;
      owner_prio  <= own_prio_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_status  <= status_d;
      rsp_wake    <= wake_d;
      rsp_wake_id <= wake_id_d;
    end
  end

`ifndef SYNTHESIS
  a_free_lock_no_waiters: assert property (@(posedge clk) disable iff (rst)
    !owner_valid |-> occ == '0)
    else $error("waiters present while lock is free");

  a_single_cell_update: assert property (@(posedge clk) disable iff (rst)
    $onehot0({wr_vec, drop_vec}))
    else $error("more than one waiter cell updated");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> rsp_valid)
    else $error("decision did not load the result register");

  a_wake_keeps_owner: assert property (@(posedge clk) disable iff (rst)
    fire && wake_d |=> owner_valid && rsp_status == ST_RELEASED)
    else $error("wake-up without a new owner");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> !req_ready && !fire)
    else $error("handshake active during the waiter walk");
`endif

endmodule

`default_nettype wire
